// ----- hw/rtl/bis_pkg.sv -----
// bilinear image scaler package: shared types, defaults and codes
// no dependencies; imported by every module of the scaler
package bis_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STEP_X     = 2'd2;
    localparam logic [1:0] CFG_STEP_Y     = 2'd3;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [23:0] rgb;
    } item_t;

    typedef struct packed {
        logic [9:0]  width;
        logic [9:0]  height;
        logic [23:0] step_x;
        logic [23:0] step_y;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- hw/rtl/bis_front.sv -----
// bilinear image scaler front: accepts beats, drops out-of-range loads, pushes the queue
// depends on bis_pkg
module bis_front
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        start,
    input  logic        operation,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  q_stat_t     q_stat,
    output logic        busy,
    output logic        push,
    output item_t       item
);

    logic accept;
    logic out_of_range;

    assign busy   = q_stat.full;
    assign accept = start && !q_stat.full;

    assign out_of_range = ({1'b0, pos_x} >= 13'(MAX_WIDTH)) ||
                          ({1'b0, pos_y} >= 13'(MAX_HEIGHT));

    assign push = accept && !((op_t'(operation) == OP_LOAD) && out_of_range);

    assign item.op    = op_t'(operation);
    assign item.pos_x = pos_x;
    assign item.pos_y = pos_y;
    assign item.rgb   = {red_in, green_in, blue_in};

endmodule

// ----- hw/rtl/bis_queue.sv -----
// bilinear image scaler item queue between front and back
// depends on bis_pkg
module bis_queue
    import bis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/bis_back.sv -----
// bilinear image scaler back: pixel store, position math, neighbour reads, blending
// depends on bis_pkg
module bis_back
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_stat_t     q_stat,
    input  item_t       q_head,
    output logic        q_pop,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [41:0] HALF_LSB = 42'h0_8000_0000;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_LOC  = 11'b000_0000_0100,
        S_ADR  = 11'b000_0000_1000,
        S_RDA  = 11'b000_0001_0000,
        S_RDB  = 11'b000_0010_0000,
        S_RDC  = 11'b000_0100_0000,
        S_RDD  = 11'b000_1000_0000,
        S_WAIT = 11'b001_0000_0000,
        S_HOR  = 11'b010_0000_0000,
        S_VER  = 11'b100_0000_0000
    } state_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [11:0] col,
                                                   input logic [11:0] row);
        return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    state_t state_reg, state_next;
    logic   done_reg;

    logic [23:0]       mem [DEPTH];
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [23:0]       rdata_reg;

    logic [11:0] px_reg, py_reg;
    logic [35:0] posx_reg, posy_reg;
    logic [9:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0] fx_reg, fy_reg;
    logic [9:0]  x0_next, x1_next, y0_next, y1_next;
    logic [15:0] fx_next, fy_next;
    logic [9:0]  lim_x, lim_y;
    logic [ADDR_W-1:0] addr_reg [4];
    logic [23:0] pix_reg [4];
    logic [23:0] top_reg [3];
    logic [23:0] bot_reg [3];
    logic [7:0]  res_reg [3];

    logic [7:0]         va [3];
    logic [7:0]         vb [3];
    logic [7:0]         vc [3];
    logic [7:0]         vd [3];
    logic signed [8:0]  dt [3];
    logic signed [8:0]  db [3];
    logic signed [25:0] pt [3];
    logic signed [25:0] pb [3];
    logic signed [25:0] st [3];
    logic signed [25:0] sb [3];
    logic signed [24:0] dv [3];
    logic signed [41:0] pv [3];
    logic signed [41:0] sv [3];
    logic [41:0]        rn [3];
    logic signed [16:0] fxs, fys;

    assign q_pop = (state_reg == S_IDLE) && !q_stat.empty;
    assign wr_en = q_pop && (q_head.op == OP_LOAD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = (q_pop && (q_head.op == OP_QUERY)) ? S_MUL : S_IDLE;
            S_MUL:   state_next = S_LOC;
            S_LOC:   state_next = S_ADR;
            S_ADR:   state_next = S_RDA;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_RDC;
            S_RDC:   state_next = S_RDD;
            S_RDD:   state_next = S_WAIT;
            S_WAIT:  state_next = S_HOR;
            S_HOR:   state_next = S_VER;
            S_VER:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_VER);
        end
    end

    // integer part, neighbour and fraction, clamped at the image edge
    always_comb
    begin
        lim_x = cfg.width - 10'd1;
        lim_y = cfg.height - 10'd1;
        if (posx_reg[35:16] >= {10'd0, lim_x})
        begin
            x0_next = lim_x;
            fx_next = 16'd0;
        end
        else
        begin
            x0_next = posx_reg[25:16];
            fx_next = posx_reg[15:0];
        end
        if (posy_reg[35:16] >= {10'd0, lim_y})
        begin
            y0_next = lim_y;
            fy_next = 16'd0;
        end
        else
        begin
            y0_next = posy_reg[25:16];
            fy_next = posy_reg[15:0];
        end
        x1_next = (x0_next < lim_x) ? x0_next + 10'd1 : lim_x;
        y1_next = (y0_next < lim_y) ? y0_next + 10'd1 : lim_y;
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = addr_reg[0];
        unique case (state_reg)
            S_RDA:   rd_addr = addr_reg[0];
            S_RDB:   rd_addr = addr_reg[1];
            S_RDC:   rd_addr = addr_reg[2];
            S_RDD:   rd_addr = addr_reg[3];
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pix_addr(q_head.pos_x, q_head.pos_y)] <= q_head.rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // per-channel lanes: horizontal then vertical blend
    always_comb
    begin
        fxs = $signed({1'b0, fx_reg});
        fys = $signed({1'b0, fy_reg});
        for (int ch = 0; ch < 3; ch++)
        begin
            va[ch] = pix_reg[0][23 - 8 * ch -: 8];
            vb[ch] = pix_reg[1][23 - 8 * ch -: 8];
            vc[ch] = pix_reg[2][23 - 8 * ch -: 8];
            vd[ch] = pix_reg[3][23 - 8 * ch -: 8];
            dt[ch] = $signed({1'b0, vb[ch]}) - $signed({1'b0, va[ch]});
            db[ch] = $signed({1'b0, vd[ch]}) - $signed({1'b0, vc[ch]});
            pt[ch] = dt[ch] * fxs;
            pb[ch] = db[ch] * fxs;
            st[ch] = $signed({2'b00, va[ch], 16'h0000}) + pt[ch];
            sb[ch] = $signed({2'b00, vc[ch], 16'h0000}) + pb[ch];
            dv[ch] = $signed({1'b0, bot_reg[ch]}) - $signed({1'b0, top_reg[ch]});
            pv[ch] = dv[ch] * fys;
            sv[ch] = $signed({2'b00, top_reg[ch], 16'h0000}) + pv[ch];
            rn[ch] = 42'(sv[ch]) + HALF_LSB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            px_reg <= q_head.pos_x;
            py_reg <= q_head.pos_y;
        end
        if (state_reg == S_MUL)
        begin
            posx_reg <= px_reg * cfg.step_x;
            posy_reg <= py_reg * cfg.step_y;
        end
        if (state_reg == S_LOC)
        begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
        if (state_reg == S_ADR)
        begin
            addr_reg[0] <= pix_addr({2'b00, x0_reg}, {2'b00, y0_reg});
            addr_reg[1] <= pix_addr({2'b00, x1_reg}, {2'b00, y0_reg});
            addr_reg[2] <= pix_addr({2'b00, x0_reg}, {2'b00, y1_reg});
            addr_reg[3] <= pix_addr({2'b00, x1_reg}, {2'b00, y1_reg});
        end
        if (state_reg == S_RDB)
        begin
            pix_reg[0] <= rdata_reg;
        end
        if (state_reg == S_RDC)
        begin
            pix_reg[1] <= rdata_reg;
        end
        if (state_reg == S_RDD)
        begin
            pix_reg[2] <= rdata_reg;
        end
        if (state_reg == S_WAIT)
        begin
            pix_reg[3] <= rdata_reg;
        end
        if (state_reg == S_HOR)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                top_reg[ch] <= st[ch][23:0];
                bot_reg[ch] <= sb[ch][23:0];
            end
        end
        if (state_reg == S_VER)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                res_reg[ch] <= rn[ch][39:32];
            end
        end
    end

    assign done      = done_reg;
    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

endmodule

// ----- hw/rtl/bilinear_image_scaler.sv -----
// bilinear image scaler top level: config registers, front, queue and back
// depends on bis_pkg, bis_front, bis_queue, bis_back
//
// channel   ports                                          handshake
// input     operation pos_x pos_y red_in green_in blue_in  start high, busy low
// result    red_out green_out blue_out                     done, one cycle
// config    cfg_index cfg_data                             cfg_wr_en, no wait
//
// a load is written to the pixel store when it leaves the queue; a query holds
// the back busy through the position multiply, the four neighbour reads through
// the single read port of the pixel store and the blend multiply stages
// busy rises while the four-beat queue is full; results cannot be held off
// reset clears control state and config; pixel store contents stay undefined
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    logic [9:0]  src_width_reg;
    logic [9:0]  src_height_reg;
    logic [23:0] step_x_reg;
    logic [23:0] step_y_reg;
    cfg_t        cfg;
    q_stat_t     q_stat;
    logic        q_push;
    logic        q_pop;
    item_t       push_item;
    item_t       q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 10'd512;
            src_height_reg <= 10'd512;
            step_x_reg     <= 24'd65536;
            step_y_reg     <= 24'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[9:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[9:0];
                CFG_STEP_X:     step_x_reg     <= cfg_data;
                CFG_STEP_Y:     step_y_reg     <= cfg_data;
                default:        step_y_reg     <= step_y_reg;
            endcase
        end
    end

    // zero acts as one, above the store size acts as the maximum
    always_comb
    begin
        priority if (src_width_reg == 10'd0)
            cfg.width = 10'd1;
        else if ({3'b000, src_width_reg} > 13'(MAX_WIDTH))
            cfg.width = 10'(MAX_WIDTH);
        else
            cfg.width = src_width_reg;
        priority if (src_height_reg == 10'd0)
            cfg.height = 10'd1;
        else if ({3'b000, src_height_reg} > 13'(MAX_HEIGHT))
            cfg.height = 10'(MAX_HEIGHT);
        else
            cfg.height = src_height_reg;
        cfg.step_x = step_x_reg;
        cfg.step_y = step_y_reg;
    end

    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .start     (start),
        .operation (operation),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (q_push),
        .item      (push_item)
    );

    bis_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    bis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back results");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");
`endif

endmodule
